// File: sv/bbc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the binary/BCD converter.
// No dependencies; every other file imports this package.
package bbc_pkg;

  localparam int DATA_W     = 32;
  localparam int NIB_W      = 4;
  localparam int MAX_DIGITS = 8;

  localparam logic MODE_BIN2BCD = 1'b0;
  localparam logic MODE_BCD2BIN = 1'b1;

  // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for any 32-bit x
  localparam logic [DATA_W-1:0] DIV10_MUL   = 32'hCCCC_CCCD;
  localparam int                DIV10_SHIFT = 35;

  // Largest binary result: every nibble at fifteen across eight digits
  localparam logic [DATA_W-1:0] BCD2BIN_MAX = 32'd166666665;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [NIB_W-1:0]  nibble_t;

  // Request travelling down the cell chain
  typedef struct packed {
    logic  mode;
    word_t data;   // remaining quotient (bin->bcd) or untouched operand (bcd->bin)
    word_t acc;    // partial result
  } lane_t;

  function automatic word_t pow10(input int exp);
    word_t w;
    w = 32'd1;
    for (int k = 0; k < exp; k++) begin
      w = 32'(w * 32'd10);
    end
    return w;
  endfunction

  function automatic logic all_decimal(input word_t w);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (w[k*NIB_W +: NIB_W] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// File: sv/bbc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the converter's request and result sides.
// Depends on bbc_pkg.
interface bbc_in_if;
  import bbc_pkg::*;
  logic  valid;
  logic  ready;
  logic  mode;
  word_t operand;

  modport source (output valid, output mode, output operand, input ready);
  modport sink   (input valid, input mode, input operand, output ready);
endinterface

interface bbc_out_if;
  import bbc_pkg::*;
  logic  valid;
  logic  ready;
  word_t converted;

  modport source (output valid, output converted, input ready);
  modport sink   (input valid, input converted, output ready);
endinterface

// File: sv/bbc_cell.sv
`timescale 1ns / 1ps
// One digit cell of the converter chain: handles decimal digit INDEX and
// registers the request for its neighbor. Depends on bbc_pkg.
module bbc_cell #(
  parameter int INDEX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  input  bbc_pkg::lane_t up_lane,
  output logic           up_ready,
  output logic           valid,
  output bbc_pkg::lane_t lane,
  input  logic           dn_ready
);
  import bbc_pkg::*;

  localparam word_t WEIGHT = pow10(INDEX);
  localparam int    SHIFT  = NIB_W * INDEX;

  logic [2*DATA_W-1:0] prod;
  word_t               quot;
  nibble_t             digit;
  nibble_t             nib;
  lane_t               lane_next;

  assign up_ready = !valid || dn_ready;

  always_comb begin
    prod  = {32'd0, up_lane.data} * {32'd0, DIV10_MUL};
    quot  = DATA_W'(prod >> DIV10_SHIFT);
    // remainder is below ten, so its low four bits are enough
    digit = nibble_t'(up_lane.data[NIB_W-1:0]
                      - ({quot[NIB_W-1:0]} << 3) - ({quot[NIB_W-1:0]} << 1));
    nib   = up_lane.data[SHIFT +: NIB_W];
    lane_next = up_lane;
    if (up_lane.mode == MODE_BIN2BCD) begin
      lane_next.data = quot;
      lane_next.acc  = up_lane.acc | (word_t'(digit) << SHIFT);
    end else begin
      lane_next.acc  = up_lane.acc + DATA_W'(word_t'(nib) * WEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      lane <= lane_next;
    end
  end

endmodule

// File: sv/binary_bcd_converter_unit.sv
`timescale 1ns / 1ps
// Binary <-> packed BCD converter: a chain of digit cells, one per decimal digit,
// accepting one request every cycle while the output side keeps up; the result is
// registered once in each cell on its way to the output. Each cell holds one request
// and does one divide-by-ten (reciprocal multiply) or one weighted nibble add. Ready
// flows back per cell, so a request is still taken while a finished result waits as
// long as some cell in the chain is empty. No state beyond the chain; reset clears the
// cell valid flags but not the request data. Depends on bbc_pkg, bbc_if and bbc_cell.
module binary_bcd_converter_unit #(
  parameter int DIGIT_COUNT = 8
) (
  input logic       clk,
  input logic       rst,
  bbc_in_if.sink    in_req,
  bbc_out_if.source out_rsp
);
  import bbc_pkg::*;

  localparam int DIGITS = (DIGIT_COUNT < 1) ? 1 :
                          (DIGIT_COUNT > MAX_DIGITS) ? MAX_DIGITS : DIGIT_COUNT;

  logic  stage_valid [DIGITS+1];
  lane_t stage_lane  [DIGITS+1];
  logic  stage_ready [DIGITS+1];
  logic [DIGITS-1:0] occupied;

  assign stage_valid[0]   = in_req.valid;
  assign stage_lane[0]    = '{mode: in_req.mode, data: in_req.operand, acc: '0};
  assign in_req.ready     = stage_ready[0];
  assign stage_ready[DIGITS] = out_rsp.ready;

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    bbc_cell #(.INDEX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stage_valid[i]),
      .up_lane  (stage_lane[i]),
      .up_ready (stage_ready[i]),
      .valid    (stage_valid[i+1]),
      .lane     (stage_lane[i+1]),
      .dn_ready (stage_ready[i+1])
    );
    assign occupied[i] = stage_valid[i+1];
  end

  assign out_rsp.valid     = stage_valid[DIGITS];
  assign out_rsp.converted = stage_lane[DIGITS].acc;

  // Binary-to-BCD results carry only decimal digits
  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    out_rsp.valid && stage_lane[DIGITS].mode == MODE_BIN2BCD
      |-> all_decimal(out_rsp.converted))
    else $error("non-decimal digit in BCD result");

  // BCD-to-binary sum never exceeds the value with fifteen in every digit
  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    out_rsp.valid && stage_lane[DIGITS].mode == MODE_BCD2BIN
      |-> out_rsp.converted <= BCD2BIN_MAX)
    else $error("binary result out of range");

  // A request taken under output stall needs a free cell somewhere
  a_free_cell: assert property (@(posedge clk) disable iff (rst)
    in_req.valid && in_req.ready && out_rsp.valid && !out_rsp.ready
      |-> $countones(occupied) < DIGITS)
    else $error("request accepted into a full chain");

  // Chain comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_rsp.valid && occupied == '0)
    else $error("chain not empty after reset");

endmodule

// File: sim/binary_bcd_converter_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for binary_bcd_converter_unit: drives conversion requests, predicts
// each packed BCD or binary result and checks the results in order under random stalls.
// Depends on bbc_pkg, bbc_if and the converter RTL.
module binary_bcd_converter_unit_test;
  import bbc_pkg::*;

  localparam int DIGITS     = 8;
  localparam int CYCLE_CAP  = 200000;
  localparam int DRAIN_WAIT = 4 * DIGITS + 8;

  typedef struct {
    logic  mode;
    word_t operand;
    word_t converted;
  } conversion_t;

  logic clk;
  logic rst;

  bbc_in_if  req_ch ();
  bbc_out_if rsp_ch ();

  binary_bcd_converter_unit #(.DIGIT_COUNT(DIGITS)) uut (
    .clk     (clk),
    .rst     (rst),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  conversion_t pending_conversions[$];
  int          error_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic word_t to_packed_bcd(input word_t value);
    word_t packed_val;
    word_t rest;
    packed_val = '0;
    rest       = value;
    for (int d = 0; d < DIGITS; d++) begin
      packed_val[d*NIB_W +: NIB_W] = NIB_W'(rest % 32'd10);
      rest = rest / 32'd10;
    end
    return packed_val;
  endfunction

  function automatic word_t from_packed_bcd(input word_t value);
    word_t sum;
    word_t weight;
    sum    = '0;
    weight = 32'd1;
    for (int d = 0; d < DIGITS; d++) begin
      sum    = sum + word_t'(value[d*NIB_W +: NIB_W]) * weight;
      weight = weight * 32'd10;
    end
    return sum;
  endfunction

  function automatic word_t predict_conversion(input logic mode, input word_t operand);
    return (mode == MODE_BCD2BIN) ? from_packed_bcd(operand) : to_packed_bcd(operand);
  endfunction

  function automatic word_t random_decimal_word();
    word_t w;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      w[d*NIB_W +: NIB_W] = NIB_W'($urandom_range(9));
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input conversion_t exp_item,
                                 input word_t got);
    $display("ERROR %0t: %s mode=%0b operand=%h got=%h want=%h", $realtime, what,
             exp_item.mode, exp_item.operand, got, exp_item.converted);
    error_count++;
  endtask

  // Hold the request until it is taken, then log its expected result.
  task automatic send_request(input logic mode, input word_t operand);
    conversion_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.mode    <= mode;
    req_ch.operand <= operand;
    do @(posedge clk); while (!req_ch.ready);
    item.mode      = mode;
    item.operand   = operand;
    item.converted = predict_conversion(mode, operand);
    pending_conversions.push_back(item);
  endtask

  task automatic test_directed_corners();
    send_request(MODE_BIN2BCD, 32'd0);
    send_request(MODE_BIN2BCD, 32'd1);
    send_request(MODE_BIN2BCD, 32'd9);
    send_request(MODE_BIN2BCD, 32'd10);
    send_request(MODE_BIN2BCD, 32'd12345678);
    send_request(MODE_BIN2BCD, 32'd99999999);
    // digits above the eighth drop out
    send_request(MODE_BIN2BCD, 32'd100000000);
    send_request(MODE_BIN2BCD, 32'd987654321);
    send_request(MODE_BIN2BCD, 32'hFFFF_FFFF);
    send_request(MODE_BIN2BCD, 32'h8000_0000);
    send_request(MODE_BIN2BCD, 32'h5555_5555);
    send_request(MODE_BCD2BIN, 32'h0000_0000);
    send_request(MODE_BCD2BIN, 32'h0000_0001);
    send_request(MODE_BCD2BIN, 32'h1000_0000);
    send_request(MODE_BCD2BIN, 32'h1234_5678);
    send_request(MODE_BCD2BIN, 32'h9999_9999);
    // nibbles above nine weigh in with no flag
    send_request(MODE_BCD2BIN, 32'h0000_000F);
    send_request(MODE_BCD2BIN, 32'hA000_0000);
    send_request(MODE_BCD2BIN, 32'hAAAA_AAAA);
    send_request(MODE_BCD2BIN, 32'h5555_5555);
    send_request(MODE_BCD2BIN, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_mix(input int count);
    int    pick;
    logic  mode;
    word_t operand;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        mode    = MODE_BCD2BIN;
        operand = random_decimal_word();
      end else if (pick < 50) begin
        mode    = MODE_BCD2BIN;
        operand = $urandom();
      end else if (pick < 75) begin
        mode    = MODE_BIN2BCD;
        operand = $urandom();
      end else if (pick < 90) begin
        mode    = MODE_BIN2BCD;
        operand = $urandom_range(99999999);
      end else begin
        mode    = (pick < 95) ? MODE_BIN2BCD : MODE_BCD2BIN;
        operand = $urandom_range(999);
      end
      send_request(mode, operand);
    end
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    conversion_t exp_item;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_conversions.size() == 0) begin
        exp_item.mode      = 1'bx;
        exp_item.operand   = 'x;
        exp_item.converted = 'x;
        report_mismatch("unexpected result", exp_item, rsp_ch.converted);
      end else begin
        exp_item = pending_conversions.pop_front();
        if (rsp_ch.converted !== exp_item.converted) begin
          report_mismatch("converted", exp_item, rsp_ch.converted);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    error_count    = 0;
    cycle_count    = 0;
    send_idle_pct  = 25;
    recv_stall_pct = 82;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.mode    = MODE_BIN2BCD;
    req_ch.operand = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_corners();
    test_random_mix(280);
    send_idle_pct  = 82;
    recv_stall_pct = 25;
    test_random_mix(300);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_mix(300);
    req_ch.valid <= 1'b0;

    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
